// ===== rtl/dbbc_pkg.sv =====
// Shared types and codes for the bracket balance checker.
`default_nettype none
package dbbc_pkg;

    // Beat action codes
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_SWAP   = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    // Kind of prefix read in flight
    localparam logic [1:0] RK_NONE = 2'd0;
    localparam logic [1:0] RK_BASE = 2'd1;
    localparam logic [1:0] RK_MIN  = 2'd2;
    localparam logic [1:0] RK_ADD  = 2'd3;

    typedef struct packed {
        logic cap_item;
        logic do_load;
        logic do_finish;
        logic sw_rd_hi;
        logic sw_cap_lo;
        logic sw_wr_lo;
        logic sw_wr_hi;
        logic cur_init;
        logic q_clr;
        logic q_rd_base;
        logic rd_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       in_range;
        logic       order_ok;
        logic       l_is_one;
        logic       bits_differ;
        logic       add_last;
        logic       q_last;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/dynamic_bracket_balance_checker_top.sv =====
// Top level of the dynamic bracket balance checker.
//
// Input channel s_*: one beat per action (load bracket, finish, swap, query).
// Result channel m_*: one m_balanced beat per in-range query, left <= right.
// Loads append a bracket and its running depth; finish makes the loaded
// length usable. Swaps exchange two differing brackets and sweep the prefix
// depths between them by +2 or -2; queries sweep the prefixes of the range
// for their minimum and compare against the depth just before the range.
// Prefix depths sit in one RAM with one read and one write port, swept one
// position per cycle. Load, finish and ignored actions do no sweep; a swap
// sweeps from lo to hi - 1 unless both brackets match, and a query sweeps
// from left to right.
// A new beat is taken only when the previous one is done; a query result
// sits in an output register and the next beat is accepted while it waits.
// If the receiver stalls, a second query holds before loading its result.
// Reset (aresetn low, synchronous) empties the string and drops any result;
// memory contents are left as they are and are never read before written.
`default_nettype none
module dynamic_bracket_balance_checker_top #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_action,
    input  wire logic                         s_bracket,
    input  wire logic [$clog2(MAX_LEN+1)-1:0] s_left,
    input  wire logic [$clog2(MAX_LEN+1)-1:0] s_right,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_balanced
);
    dbbc_pkg::cmd_t cmd;
    dbbc_pkg::sts_t sts;

    dbbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dbbc_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_action   (s_action),
        .s_bracket  (s_bracket),
        .s_left     (s_left),
        .s_right    (s_right),
        .cmd        (cmd),
        .sts        (sts),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_balanced (m_balanced)
    );
endmodule
`default_nettype wire

// ===== rtl/dbbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dbbc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [$clog2(D)-1:0] wr_addr,
    input  wire logic [W-1:0]         wr_data,
    input  wire logic [$clog2(D)-1:0] rd_addr,
    output logic      [W-1:0]         rd_data
);
    logic [W-1:0] mem [D];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/dbbc_datapath.sv =====
// Datapath: item registers, bracket and prefix memories, range sweep, result register.
`default_nettype none
module dbbc_datapath #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [1:0]                     s_action,
    input  wire logic                           s_bracket,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]   s_left,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]   s_right,
    input  wire dbbc_pkg::cmd_t                 cmd,
    output dbbc_pkg::sts_t                      sts,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_balanced
);
    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int DW = $clog2(MAX_LEN) + 2;
    localparam logic signed [DW-1:0] MIN_INIT = {1'b0, {(DW-1){1'b1}}};

    logic [1:0]           act_reg;
    logic                 br_reg;
    logic [PW-1:0]        l_reg, r_reg;
    logic [PW-1:0]        len_reg, rdylen_reg, cur_reg;
    logic signed [DW-1:0] run_reg;
    logic                 bitlo_reg;
    logic [1:0]           rk_reg, rk_next;
    logic [AW-1:0]        wb_addr_reg;
    logic signed [DW-1:0] base_reg, min_reg, last_reg;
    logic                 mval_reg, mbal_reg;

    logic [PW-1:0]        lo, hi, lo_m1, hi_m1, l_m2, cur_m1;
    logic                 full, load_en;
    logic signed [DW-1:0] run_new, delta, pre_rd, pre_wdata;
    logic                 bit_rd, bit_wdata, bit_wen, pre_wen;
    logic [AW-1:0]        bit_waddr, bit_raddr, pre_waddr, pre_raddr;

    // Order the swap positions
    assign lo    = (l_reg < r_reg) ? l_reg : r_reg;
    assign hi    = (l_reg < r_reg) ? r_reg : l_reg;
    assign lo_m1 = lo - PW'(1);
    assign hi_m1 = hi - PW'(1);
    assign l_m2  = l_reg - PW'(2);
    assign cur_m1 = cur_reg - PW'(1);

    assign full    = (len_reg == PW'(MAX_LEN));
    assign load_en = cmd.do_load && !full;
    assign run_new = br_reg ? run_reg + DW'(1) : run_reg - DW'(1);
    assign delta   = bitlo_reg ? -DW'(2) : DW'(2);

    // Bracket memory port muxing
    assign bit_wen   = load_en || cmd.sw_wr_lo || cmd.sw_wr_hi;
    assign bit_waddr = load_en ? len_reg[AW-1:0] :
                       (cmd.sw_wr_lo ? lo_m1[AW-1:0] : hi_m1[AW-1:0]);
    assign bit_wdata = load_en ? br_reg : (cmd.sw_wr_lo ? bit_rd : bitlo_reg);
    assign bit_raddr = cmd.sw_rd_hi ? hi_m1[AW-1:0] : lo_m1[AW-1:0];

    dbbc_ram #(.W(1), .D(MAX_LEN)) u_bits (
        .aclk    (aclk),
        .wr_en   (bit_wen),
        .wr_addr (bit_waddr),
        .wr_data (bit_wdata),
        .rd_addr (bit_raddr),
        .rd_data (bit_rd)
    );

    // Prefix memory port muxing
    assign pre_wen   = load_en || (rk_reg == dbbc_pkg::RK_ADD);
    assign pre_waddr = (rk_reg == dbbc_pkg::RK_ADD) ? wb_addr_reg : len_reg[AW-1:0];
    assign pre_wdata = (rk_reg == dbbc_pkg::RK_ADD) ? pre_rd + delta : run_new;
    assign pre_raddr = cmd.q_rd_base ? l_m2[AW-1:0] : cur_m1[AW-1:0];

    dbbc_ram #(.W(DW), .D(MAX_LEN)) u_prefix (
        .aclk    (aclk),
        .wr_en   (pre_wen),
        .wr_addr (pre_waddr),
        .wr_data (pre_wdata),
        .rd_addr (pre_raddr),
        .rd_data (pre_rd)
    );

    // Tag the read issued this cycle
    always_comb begin
        rk_next = dbbc_pkg::RK_NONE;
        if (cmd.q_rd_base) begin
            rk_next = dbbc_pkg::RK_BASE;
        end else if (cmd.rd_step) begin
            rk_next = (act_reg == dbbc_pkg::ACT_SWAP) ? dbbc_pkg::RK_ADD : dbbc_pkg::RK_MIN;
        end
    end

    // Status toward the controller
    always_comb begin
        sts.act         = act_reg;
        sts.in_range    = (l_reg != '0) && (r_reg != '0) &&
                          (l_reg <= rdylen_reg) && (r_reg <= rdylen_reg);
        sts.order_ok    = (l_reg <= r_reg);
        sts.l_is_one    = (l_reg == PW'(1));
        sts.bits_differ = (bit_rd != bitlo_reg);
        sts.add_last    = (cur_reg == hi_m1);
        sts.q_last      = (cur_reg == r_reg);
        sts.out_free    = !mval_reg || m_ready;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            rdylen_reg <= '0;
            run_reg    <= '0;
            rk_reg     <= dbbc_pkg::RK_NONE;
            mval_reg   <= 1'b0;
        end else begin
            rk_reg <= rk_next;
            if (load_en) begin
                len_reg <= len_reg + PW'(1);
                run_reg <= run_new;
            end
            if (cmd.do_finish) begin
                rdylen_reg <= len_reg;
            end
            if (cmd.out_load) begin
                mval_reg <= 1'b1;
            end else if (m_ready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.cap_item) begin
            act_reg <= s_action;
            br_reg  <= s_bracket;
            l_reg   <= s_left;
            r_reg   <= s_right;
        end
        if (cmd.sw_cap_lo) begin
            bitlo_reg <= bit_rd;
        end
        if (cmd.cur_init) begin
            cur_reg <= (act_reg == dbbc_pkg::ACT_SWAP) ? lo : l_reg;
        end else if (cmd.rd_step) begin
            cur_reg <= cur_reg + PW'(1);
        end
        wb_addr_reg <= cur_m1[AW-1:0];
        if (cmd.q_clr) begin
            base_reg <= '0;
            min_reg  <= MIN_INIT;
        end else if (rk_reg == dbbc_pkg::RK_BASE) begin
            base_reg <= pre_rd;
        end else if (rk_reg == dbbc_pkg::RK_MIN) begin
            last_reg <= pre_rd;
            if (pre_rd < min_reg) begin
                min_reg <= pre_rd;
            end
        end
        if (cmd.out_load) begin
            mbal_reg <= (min_reg >= base_reg) && (last_reg == base_reg);
        end
    end

    assign m_valid    = mval_reg;
    assign m_balanced = mbal_reg;

    a_no_port_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.do_load && rk_reg == dbbc_pkg::RK_ADD))
        else $error("load write collides with sweep write");
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_step |-> (cur_reg != '0) && (cur_reg <= rdylen_reg))
        else $error("sweep cursor out of range");
    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mval_reg || m_ready))
        else $error("result overwritten before taken");
endmodule
`default_nettype wire

// ===== rtl/dbbc_ctrl.sv =====
// Controller state machine sequencing load, finish, swap and query beats.
`default_nettype none
module dbbc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire dbbc_pkg::sts_t sts,
    output dbbc_pkg::cmd_t      cmd
);
    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_EXEC    = 12'b000000000010,
        S_SW_A    = 12'b000000000100,
        S_SW_B    = 12'b000000001000,
        S_SW_C    = 12'b000000010000,
        S_SW_D    = 12'b000000100000,
        S_ADD     = 12'b000001000000,
        S_ADD_END = 12'b000010000000,
        S_Q_BASE  = 12'b000100000000,
        S_Q_RUN   = 12'b001000000000,
        S_Q_END   = 12'b010000000000,
        S_RESULT  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap_item = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                case (sts.act)
                    dbbc_pkg::ACT_LOAD:   cmd.do_load = 1'b1;
                    dbbc_pkg::ACT_FINISH: cmd.do_finish = 1'b1;
                    dbbc_pkg::ACT_SWAP: begin
                        if (sts.in_range) state_next = S_SW_A;
                    end
                    dbbc_pkg::ACT_QUERY: begin
                        if (sts.in_range && sts.order_ok) state_next = S_Q_BASE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SW_A: state_next = S_SW_B;
            S_SW_B: begin
                cmd.sw_rd_hi  = 1'b1;
                cmd.sw_cap_lo = 1'b1;
                state_next    = S_SW_C;
            end
            S_SW_C: begin
                if (sts.bits_differ) begin
                    cmd.sw_wr_lo = 1'b1;
                    cmd.cur_init = 1'b1;
                    state_next   = S_SW_D;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_SW_D: begin
                cmd.sw_wr_hi = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD: begin
                cmd.rd_step = 1'b1;
                if (sts.add_last) state_next = S_ADD_END;
            end
            S_ADD_END: state_next = S_IDLE;
            S_Q_BASE: begin
                cmd.q_clr     = 1'b1;
                cmd.cur_init  = 1'b1;
                cmd.q_rd_base = !sts.l_is_one;
                state_next    = S_Q_RUN;
            end
            S_Q_RUN: begin
                cmd.rd_step = 1'b1;
                if (sts.q_last) state_next = S_Q_END;
            end
            S_Q_END: state_next = S_RESULT;
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_exec_after_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_item |=> state_reg == S_EXEC)
        else $error("captured beat not executed");
    a_swap_write_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sw_wr_hi |-> $past(cmd.sw_wr_lo))
        else $error("swap writes out of order");
    a_result_after_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !cmd.rd_step && !cmd.cap_item)
        else $error("result issued during sweep");
endmodule
`default_nettype wire
